@@ rtl/core/vn2d_pkg.sv @@
// Shared constants for the 2D vector normalization core.
package vn2d_pkg;
    localparam int IN_WIDTH_DEF  = 16;
    localparam int FRAC_BITS_DEF = 14;
endpackage

@@ rtl/core/vn2d_if.sv @@
// Valid/ready channel interfaces for input vectors and unit-vector results.
interface vn2d_in_if #(parameter int IN_WIDTH = vn2d_pkg::IN_WIDTH_DEF);
    logic                       valid;
    logic                       ready;
    logic signed [IN_WIDTH-1:0] x_in;
    logic signed [IN_WIDTH-1:0] y_in;
    modport source (output valid, x_in, y_in, input ready);
    modport sink (input valid, x_in, y_in, output ready);
endinterface

interface vn2d_out_if #(parameter int OUT_WIDTH = vn2d_pkg::FRAC_BITS_DEF + 2);
    logic                        valid;
    logic                        ready;
    logic signed [OUT_WIDTH-1:0] unit_x;
    logic signed [OUT_WIDTH-1:0] unit_y;
    logic                        ok;
    modport source (output valid, unit_x, unit_y, ok, input ready);
    modport sink (input valid, unit_x, unit_y, ok, output ready);
endinterface

@@ rtl/core/vector_normalize_2d_core.sv @@
// Pipelined 2D vector normalization to signed Q2.FRAC_BITS unit components.
// Stages: input squaring, setup, one search stage per result bit, then output.
// Throughput: one beat per cycle unless the output stalls.
// A stall on the output freezes every stage; nothing is lost or repeated.
// Reset clears all valid bits; payload registers are not reset.
module vector_normalize_2d_core #(
    parameter int IN_WIDTH  = vn2d_pkg::IN_WIDTH_DEF,
    parameter int FRAC_BITS = vn2d_pkg::FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    vn2d_in_if.sink    vec,
    vn2d_out_if.source norm
);
    localparam int OUT_WIDTH = FRAC_BITS + 2;
    localparam int SQ_WIDTH  = 2 * IN_WIDTH;
    localparam int W         = 2 * IN_WIDTH + 2 * FRAC_BITS + 4;

    logic en;
    assign en        = !norm.valid || norm.ready;
    assign vec.ready = en;

    // input stage: magnitudes squared
    logic                valid_a_reg;
    logic [SQ_WIDTH-1:0] sqx_reg, sqy_reg;
    logic                negx_a_reg, negy_a_reg, nzx_a_reg, nzy_a_reg;
    logic [IN_WIDTH-1:0] magx, magy;

    assign magx = vec.x_in[IN_WIDTH-1] ? IN_WIDTH'(-vec.x_in) : IN_WIDTH'(vec.x_in);
    assign magy = vec.y_in[IN_WIDTH-1] ? IN_WIDTH'(-vec.y_in) : IN_WIDTH'(vec.y_in);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_a_reg <= vec.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg    <= magx * magx;
            sqy_reg    <= magy * magy;
            negx_a_reg <= vec.x_in[IN_WIDTH-1];
            negy_a_reg <= vec.y_in[IN_WIDTH-1];
            nzx_a_reg  <= magx != '0;
            nzy_a_reg  <= magy != '0;
        end
    end

    // search stages: index s holds state before bit FRAC_BITS-1-s is decided
    logic                 valid_reg [0:FRAC_BITS];
    logic [W-1:0]         len_reg   [0:FRAC_BITS];
    logic [W-1:0]         ax_reg    [0:FRAC_BITS];
    logic [W-1:0]         ay_reg    [0:FRAC_BITS];
    logic [W-1:0]         px_reg    [0:FRAC_BITS];
    logic [W-1:0]         py_reg    [0:FRAC_BITS];
    logic [W-1:0]         tx_reg    [0:FRAC_BITS];
    logic [W-1:0]         ty_reg    [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] ux_reg    [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] uy_reg    [0:FRAC_BITS];
    logic                 negx_reg  [0:FRAC_BITS];
    logic                 negy_reg  [0:FRAC_BITS];
    logic                 nzx_reg   [0:FRAC_BITS];
    logic                 nzy_reg   [0:FRAC_BITS];

    logic [W-1:0] len_next;
    logic [W-1:0] ax_next, ay_next;
    assign len_next = W'(sqx_reg) + W'(sqy_reg);
    assign ax_next  = W'(sqx_reg) << (2 * FRAC_BITS + 2);
    assign ay_next  = W'(sqy_reg) << (2 * FRAC_BITS + 2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= valid_a_reg;
        end
    end

    // nz flags mark a magnitude of at least one after rounding
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len_reg[0]  <= len_next;
            ax_reg[0]   <= ax_next;
            ay_reg[0]   <= ay_next;
            px_reg[0]   <= len_next;
            py_reg[0]   <= len_next;
            tx_reg[0]   <= len_next;
            ty_reg[0]   <= len_next;
            ux_reg[0]   <= '0;
            uy_reg[0]   <= '0;
            negx_reg[0] <= negx_a_reg;
            negy_reg[0] <= negy_a_reg;
            nzx_reg[0]  <= nzx_a_reg && (len_next <= ax_next);
            nzy_reg[0]  <= nzy_a_reg && (len_next <= ay_next);
        end
    end

    for (genvar s = 0; s < FRAC_BITS; s++)
    begin : g_stage
        localparam int K = FRAC_BITS - 1 - s;
        logic [W-1:0]         candx, candy, step_p, step_t;
        logic                 takex, takey;
        logic [FRAC_BITS-1:0] ux_next, uy_next;

        always_comb
        begin
            step_p  = len_reg[s] << (2 * K + 2);
            step_t  = len_reg[s] << (K + 1);
            candx   = px_reg[s] + (tx_reg[s] << (K + 2)) + step_p;
            candy   = py_reg[s] + (ty_reg[s] << (K + 2)) + step_p;
            takex   = candx <= ax_reg[s];
            takey   = candy <= ay_reg[s];
            ux_next = ux_reg[s];
            uy_next = uy_reg[s];
            ux_next[K] = takex;
            uy_next[K] = takey;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[s+1] <= valid_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                len_reg[s+1]  <= len_reg[s];
                ax_reg[s+1]   <= ax_reg[s];
                ay_reg[s+1]   <= ay_reg[s];
                px_reg[s+1]   <= takex ? candx : px_reg[s];
                py_reg[s+1]   <= takey ? candy : py_reg[s];
                tx_reg[s+1]   <= takex ? tx_reg[s] + step_t : tx_reg[s];
                ty_reg[s+1]   <= takey ? ty_reg[s] + step_t : ty_reg[s];
                ux_reg[s+1]   <= ux_next;
                uy_reg[s+1]   <= uy_next;
                negx_reg[s+1] <= negx_reg[s];
                negy_reg[s+1] <= negy_reg[s];
                nzx_reg[s+1]  <= nzx_reg[s];
                nzy_reg[s+1]  <= nzy_reg[s];
            end
        end
    end

    // output stage: add one, apply sign
    logic [OUT_WIDTH-1:0] nx, ny;
    logic                 out_valid_reg, ok_reg;
    logic [OUT_WIDTH-1:0] unit_x_reg, unit_y_reg;

    assign nx = nzx_reg[FRAC_BITS] ? OUT_WIDTH'(ux_reg[FRAC_BITS]) + OUT_WIDTH'(1) : '0;
    assign ny = nzy_reg[FRAC_BITS] ? OUT_WIDTH'(uy_reg[FRAC_BITS]) + OUT_WIDTH'(1) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= valid_reg[FRAC_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unit_x_reg <= negx_reg[FRAC_BITS] ? -nx : nx;
            unit_y_reg <= negy_reg[FRAC_BITS] ? -ny : ny;
            ok_reg     <= len_reg[FRAC_BITS] != '0;
        end
    end

    assign norm.valid  = out_valid_reg;
    assign norm.unit_x = unit_x_reg;
    assign norm.unit_y = unit_y_reg;
    assign norm.ok     = ok_reg;
endmodule
